### rtl/accel_vibration_moving_average_core_assert.svh
// Assertion macros shared by the checker of the vibration core.
`ifndef ACCEL_VIBRATION_MOVING_AVERAGE_CORE_ASSERT_SVH
`define ACCEL_VIBRATION_MOVING_AVERAGE_CORE_ASSERT_SVH

// Check on every rising edge of clk_i outside reset.
`define AVMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge of clk_i, reset included.
`define AVMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/avma_pkg.sv
// Shared widths, codes and controller command type of the vibration core.
`timescale 1ns / 1ps

package avma_pkg;

  localparam int unsigned AccelW   = 16;
  localparam int unsigned OffsetW  = 13;
  localparam int unsigned GravW    = 15;
  localparam int unsigned SumW     = 17;
  localparam int unsigned MagW     = 16;
  localparam int unsigned SqW      = 32;
  localparam int unsigned RemW     = 18;
  localparam int unsigned LevelW   = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  localparam int unsigned SqSteps   = 4;
  localparam int unsigned RootSteps = 16;
  localparam int unsigned CntW      = $clog2(RootSteps);

  localparam logic signed [OffsetW-1:0] OffsetXRst = 13'sd240;
  localparam logic signed [OffsetW-1:0] OffsetYRst = -13'sd150;
  localparam logic signed [OffsetW-1:0] OffsetZRst = 13'sd1876;
  localparam logic [GravW-1:0]          GravRst    = 15'd16384;

  typedef enum logic [CfgIdxW-1:0] {
    RegOffsetX = 2'd0,
    RegOffsetY = 2'd1,
    RegOffsetZ = 2'd2,
    RegGravity = 2'd3
  } avma_reg_e;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } avma_axis_e;

  typedef struct packed {
    logic       load;
    logic       sq_step;
    avma_axis_e axis;
    logic       root_step;
    logic       rd_en;
    logic       commit;
    logic       div;
    logic       out_load;
  } avma_cmd_t;

endpackage

### rtl/avma_sample_if.sv
// Request channel carrying one raw three-axis sample.
`timescale 1ns / 1ps

interface avma_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [avma_pkg::AccelW-1:0] accel_x;
  logic signed [avma_pkg::AccelW-1:0] accel_y;
  logic signed [avma_pkg::AccelW-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

### rtl/avma_result_if.sv
// Result channel carrying the smoothed and instantaneous vibration levels.
`timescale 1ns / 1ps

interface avma_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [avma_pkg::LevelW-1:0] smoothed_level;
  logic signed [avma_pkg::LevelW-1:0] instant_level;

  modport source (output valid, output smoothed_level, output instant_level, input ready);
  modport sink (input valid, input smoothed_level, input instant_level, output ready);
endinterface

### rtl/avma_cfg_if.sv
// Register write channel: register index and write data.
`timescale 1ns / 1ps

interface avma_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [avma_pkg::CfgIdxW-1:0]  index;
  logic [avma_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/avma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module avma_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 10,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/avma_dp.sv
// Datapath: registers, squaring unit, bit-serial root, window store and averaging.
`timescale 1ns / 1ps

module avma_dp #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  avma_pkg::avma_cmd_t                  cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [avma_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [avma_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic signed [avma_pkg::AccelW-1:0]  accel_x_i,
  input  logic signed [avma_pkg::AccelW-1:0]  accel_y_i,
  input  logic signed [avma_pkg::AccelW-1:0]  accel_z_i,
  output logic signed [avma_pkg::LevelW-1:0]  smoothed_o,
  output logic signed [avma_pkg::LevelW-1:0]  instant_o
);

  localparam int unsigned PosW  = $clog2(WINDOW);
  localparam int unsigned TotW  = avma_pkg::LevelW + PosW;
  localparam int unsigned NumW  = TotW + $clog2(WINDOW + 1);
  localparam int unsigned Shift = NumW + PosW;
  localparam int unsigned MulW  = NumW + 1;
  localparam int unsigned ProdW = NumW + MulW;
  localparam logic [63:0] Recip64 = ((64'd1 << Shift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MulW-1:0] Recip = Recip64[MulW-1:0];
  localparam logic [63:0] Bias64 = 64'(WINDOW) << (TotW - 1);
  localparam logic [NumW-1:0] Bias = Bias64[NumW-1:0];

  // Calibration registers
  logic signed [avma_pkg::OffsetW-1:0] off_x_q, off_y_q, off_z_q;
  logic [avma_pkg::GravW-1:0]          grav_q;

  // Sample and magnitude working registers
  logic signed [avma_pkg::SumW-1:0] sx_q, sy_q, sz_q;
  logic [avma_pkg::SqW-1:0]         prod_q, acc_q;
  logic [avma_pkg::RemW-1:0]        rem_q;
  logic [avma_pkg::MagW-1:0]        root_q;
  logic signed [avma_pkg::LevelW-1:0] level_q, smooth_q, out_smooth_q, out_inst_q;

  // Window state
  logic signed [TotW-1:0] total_q;
  logic [PosW-1:0]        pos_q;
  logic [WINDOW-1:0]      vld_q;

  logic signed [avma_pkg::SumW-1:0]   sel;
  logic [avma_pkg::MagW-1:0]          mag_in;
  logic [avma_pkg::SqW-1:0]           sq;
  logic [avma_pkg::RemW-1:0]          rem_sh, trial;
  logic                               ge;
  logic signed [avma_pkg::LevelW-1:0] level, old;
  logic [avma_pkg::LevelW-1:0]        rd_data, wr_data;
  logic signed [TotW-1:0]             total_nxt;
  logic [PosW-1:0]                    pos_nxt;
  logic [NumW-1:0]                    num;
  logic [ProdW-1:0]                   prod_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= avma_pkg::OffsetXRst;
      off_y_q <= avma_pkg::OffsetYRst;
      off_z_q <= avma_pkg::OffsetZRst;
      grav_q  <= avma_pkg::GravRst;
    end else if (cfg_we_i) begin
      unique case (avma_pkg::avma_reg_e'(cfg_idx_i))
        avma_pkg::RegOffsetX: off_x_q <= signed'(cfg_data_i[avma_pkg::OffsetW-1:0]);
        avma_pkg::RegOffsetY: off_y_q <= signed'(cfg_data_i[avma_pkg::OffsetW-1:0]);
        avma_pkg::RegOffsetZ: off_z_q <= signed'(cfg_data_i[avma_pkg::OffsetW-1:0]);
        avma_pkg::RegGravity: grav_q  <= cfg_data_i[avma_pkg::GravW-1:0];
      endcase
    end
  end

  // Square one axis a cycle; the registered product is added in the following cycle
  always_comb begin
    unique case (cmd_i.axis)
      avma_pkg::AxisX: sel = sx_q;
      avma_pkg::AxisY: sel = sy_q;
      default:         sel = sz_q;
    endcase
    mag_in = sel[avma_pkg::SumW-1] ? avma_pkg::MagW'(-sel) : avma_pkg::MagW'(sel);
    sq     = avma_pkg::SqW'(mag_in) * avma_pkg::SqW'(mag_in);
  end

  // One root bit per step, two radicand bits shifted in from the top of acc_q
  assign rem_sh = {rem_q[avma_pkg::RemW-3:0], acc_q[avma_pkg::SqW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  assign level     = signed'({1'b0, root_q}) - signed'({2'b00, grav_q});
  assign old       = vld_q[pos_q] ? signed'(rd_data) : '0;
  assign total_nxt = total_q - TotW'(old) + TotW'(level);
  assign pos_nxt   = (pos_q == PosW'(WINDOW - 1)) ? '0 : pos_q + PosW'(1);
  assign wr_data   = level;

  // Floor division by the window length: bias to non-negative, multiply by reciprocal
  assign num      = NumW'(total_q) + Bias;
  assign prod_div = ProdW'(num) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q   <= avma_pkg::SumW'(accel_x_i) + avma_pkg::SumW'(off_x_q);
      sy_q   <= avma_pkg::SumW'(accel_y_i) + avma_pkg::SumW'(off_y_q);
      sz_q   <= avma_pkg::SumW'(accel_z_i) + avma_pkg::SumW'(off_z_q);
      prod_q <= '0;
      acc_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sq_step) begin
      prod_q <= sq;
      acc_q  <= acc_q + prod_q;
    end
    if (cmd_i.root_step) begin
      acc_q  <= acc_q << 2;
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[avma_pkg::MagW-2:0], ge};
    end
    if (cmd_i.commit) begin
      level_q <= level;
    end
    if (cmd_i.div) begin
      // Bias term vanishes in the low bits of the quotient
      smooth_q <= signed'(prod_div[Shift +: avma_pkg::LevelW]);
    end
    if (cmd_i.out_load) begin
      out_smooth_q <= smooth_q;
      out_inst_q   <= level_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      pos_q   <= '0;
      vld_q   <= '0;
    end else if (cmd_i.commit) begin
      total_q      <= total_nxt;
      pos_q        <= pos_nxt;
      vld_q[pos_q] <= 1'b1;
    end
  end

  avma_ram #(
    .Width (avma_pkg::LevelW),
    .Depth (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (pos_q),
    .wdata_i (wr_data),
    .re_i    (cmd_i.rd_en),
    .raddr_i (pos_q),
    .rdata_o (rd_data)
  );

  assign smoothed_o = out_smooth_q;
  assign instant_o  = out_inst_q;

endmodule

### rtl/avma_ctrl.sv
// Controller: sequences squaring, root steps, window update, divide and result hand-off.
`timescale 1ns / 1ps

module avma_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output avma_pkg::avma_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StSquare = 6'b000010,
    StRoot   = 6'b000100,
    StCommit = 6'b001000,
    StDivide = 6'b010000,
    StOutput = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic [avma_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StSquare;
        end
      end
      StSquare: begin
        cmd_o.sq_step = 1'b1;
        cmd_o.axis    = avma_pkg::avma_axis_e'(cnt_q[1:0]);
        if (cnt_q == avma_pkg::CntW'(avma_pkg::SqSteps - 1)) begin
          cnt_d   = '0;
          state_d = StRoot;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        // fetch the entry about to be replaced while the root runs
        cmd_o.rd_en     = (cnt_q == '0);
        if (cnt_q == avma_pkg::CntW'(avma_pkg::RootSteps - 1)) begin
          cnt_d   = '0;
          state_d = StCommit;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StDivide;
      end
      StDivide: begin
        cmd_o.div = 1'b1;
        state_d   = StOutput;
      end
      StOutput: begin
        // hold here while the previous result is still waiting
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/accel_vibration_moving_average_core.sv
// Top level of the accelerometer vibration level core with moving average.
//
// Channels: sample_i takes one raw x/y/z request; result_o gives one result per
// request (smoothed_level, instant_level); cfg_i writes the offset and one-g
// registers by index and is always ready. Write registers only while idle.
// Throughput: a new request is taken only in idle, once the last one is loaded
// into the output register; each request passes acceptance, the shared squaring
// multiplier, the 16-step bit-serial square root, window update, reciprocal
// divide and result load.
// Reset: registers take their default calibration, the window reads as zeros
// through per-entry valid flags, so no clearing pass is needed.
// Stall: the result sits in the output register until taken; a new request is
// accepted and worked on meanwhile, and its result waits in the last step
// until the output register is free.
`timescale 1ns / 1ps

module accel_vibration_moving_average_core #(
  parameter int unsigned WINDOW = 10
) (
  input logic           clk_i,
  input logic           rst_ni,
  avma_sample_if.sink   sample_i,
  avma_result_if.source result_o,
  avma_cfg_if.sink      cfg_i
);

  avma_pkg::avma_cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  avma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  avma_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .accel_x_i  (sample_i.accel_x),
    .accel_y_i  (sample_i.accel_y),
    .accel_z_i  (sample_i.accel_z),
    .smoothed_o (result_o.smoothed_level),
    .instant_o  (result_o.instant_level)
  );

endmodule

### rtl/avma_chk.sv
// Port-level checker for the vibration core, bound to the top level.
`timescale 1ns / 1ps
`include "accel_vibration_moving_average_core_assert.svh"

module avma_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [avma_pkg::LevelW-1:0]       smoothed_i,
  input logic [avma_pkg::LevelW-1:0]       instant_i
);

  `AVMA_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(smoothed_i) && $stable(instant_i), "stalled result changed")
  `AVMA_ASSERT(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i, "request accepted while busy")
  `AVMA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_i, "result valid after reset")
  `AVMA_ASSERT(a_instant_floor, out_valid_i |-> $signed(instant_i) >= -17'sd32767, "instant level below range")
  `AVMA_ASSERT(a_smooth_floor, out_valid_i |-> $signed(smoothed_i) >= -17'sd32767, "smoothed level below range")

endmodule

bind accel_vibration_moving_average_core avma_chk u_avma_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .smoothed_i  (result_o.smoothed_level),
  .instant_i   (result_o.instant_level)
);

### tb/sv/tb_accel_vibration_moving_average_core.sv
// Self-checking testbench for the accelerometer vibration level core.
`timescale 1ns / 1ps

module tb_accel_vibration_moving_average_core;

  localparam int AvgWindow = 10;
  localparam int SettleCycles = 30;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic signed [avma_pkg::AccelW-1:0] x;
    logic signed [avma_pkg::AccelW-1:0] y;
    logic signed [avma_pkg::AccelW-1:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [avma_pkg::LevelW-1:0] smoothed;
    logic signed [avma_pkg::LevelW-1:0] instant;
  } level_pair_t;

  typedef struct packed {
    avma_pkg::avma_reg_e           index;
    logic [avma_pkg::CfgDataW-1:0] data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Testbench-side drive registers, known from time zero
  logic                               smp_valid = 1'b0;
  logic signed [avma_pkg::AccelW-1:0] smp_x = '0;
  logic signed [avma_pkg::AccelW-1:0] smp_y = '0;
  logic signed [avma_pkg::AccelW-1:0] smp_z = '0;
  logic                               res_ready = 1'b0;
  logic                               cfg_valid = 1'b0;
  avma_pkg::avma_reg_e                cfg_index = avma_pkg::RegOffsetX;
  logic [avma_pkg::CfgDataW-1:0]      cfg_data = '0;

  avma_sample_if sample_bus ();
  avma_result_if result_bus ();
  avma_cfg_if    cfg_bus ();

  assign sample_bus.valid   = smp_valid;
  assign sample_bus.accel_x = smp_x;
  assign sample_bus.accel_y = smp_y;
  assign sample_bus.accel_z = smp_z;
  assign result_bus.ready   = res_ready;
  assign cfg_bus.valid      = cfg_valid;
  assign cfg_bus.index      = cfg_index;
  assign cfg_bus.data       = cfg_data;

  accel_vibration_moving_average_core #(
    .WINDOW(AvgWindow)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  always #5 clk_i = ~clk_i;

  // Shadow calibration and window state
  logic signed [avma_pkg::OffsetW-1:0] ofs_x = avma_pkg::OffsetXRst;
  logic signed [avma_pkg::OffsetW-1:0] ofs_y = avma_pkg::OffsetYRst;
  logic signed [avma_pkg::OffsetW-1:0] ofs_z = avma_pkg::OffsetZRst;
  logic [avma_pkg::GravW-1:0]          grav = avma_pkg::GravRst;
  int                                  win_level [AvgWindow];
  int                                  win_pos = 0;
  int                                  win_total = 0;

  sample_t     sample_backlog [$];
  reg_write_t  reg_writes [$];
  level_pair_t pending_levels [$];
  sample_t     next_sample;
  reg_write_t  next_write;
  level_pair_t got_pair;
  level_pair_t want_pair;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic recv_hold = 1'b0;
  int errors = 0;

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root + (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic void update_window(input logic signed [avma_pkg::AccelW-1:0] ax,
                                        input logic signed [avma_pkg::AccelW-1:0] ay,
                                        input logic signed [avma_pkg::AccelW-1:0] az);
    longint sx;
    longint sy;
    longint sz;
    longint unsigned energy;
    int level;
    int avg;
    level_pair_t pair;
    sx = longint'(ax) + longint'(ofs_x);
    sy = longint'(ay) + longint'(ofs_y);
    sz = longint'(az) + longint'(ofs_z);
    energy = sx * sx + sy * sy + sz * sz;
    level = int'(floor_root(energy)) - int'(grav);
    win_total = win_total - win_level[win_pos] + level;
    win_level[win_pos] = level;
    win_pos = (win_pos + 1) % AvgWindow;
    avg = win_total / AvgWindow;
    // floor toward minus infinity
    if (win_total % AvgWindow != 0 && win_total < 0) avg = avg - 1;
    pair.smoothed = avg[avma_pkg::LevelW-1:0];
    pair.instant = level[avma_pkg::LevelW-1:0];
    pending_levels.push_back(pair);
  endfunction

  function automatic void apply_reg(input avma_pkg::avma_reg_e idx,
                                    input logic [avma_pkg::CfgDataW-1:0] d);
    case (idx)
      avma_pkg::RegOffsetX: ofs_x = d[avma_pkg::OffsetW-1:0];
      avma_pkg::RegOffsetY: ofs_y = d[avma_pkg::OffsetW-1:0];
      avma_pkg::RegOffsetZ: ofs_z = d[avma_pkg::OffsetW-1:0];
      avma_pkg::RegGravity: grav = d[avma_pkg::GravW-1:0];
      default: ;
    endcase
  endfunction

  function automatic void report(input string msg);
    errors++;
    if (errors <= MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid <= 1'b0;
    end else begin
      if (smp_valid && sample_bus.ready) begin
        update_window(smp_x, smp_y, smp_z);
      end
      if (!smp_valid || sample_bus.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sample = sample_backlog.pop_front();
          smp_valid <= 1'b1;
          smp_x <= next_sample.x;
          smp_y <= next_sample.y;
          smp_z <= next_sample.z;
        end else begin
          smp_valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_bus.ready) begin
        apply_reg(cfg_index, cfg_data);
      end
      if (!cfg_valid || cfg_bus.ready) begin
        if (reg_writes.size() != 0) begin
          next_write = reg_writes.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= next_write.index;
          cfg_data <= next_write.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_ready && result_bus.valid) begin
        got_pair.smoothed = result_bus.smoothed_level;
        got_pair.instant = result_bus.instant_level;
        if (pending_levels.size() == 0) begin
          report($sformatf("unexpected result smoothed=%0d instant=%0d",
                           got_pair.smoothed, got_pair.instant));
        end else begin
          want_pair = pending_levels.pop_front();
          if (got_pair.smoothed !== want_pair.smoothed)
            report($sformatf("smoothed_level expected %0d got %0d",
                             want_pair.smoothed, got_pair.smoothed));
          if (got_pair.instant !== want_pair.instant)
            report($sformatf("instant_level expected %0d got %0d",
                             want_pair.instant, got_pair.instant));
        end
      end
      res_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (sample_backlog.size() != 0 || smp_valid || pending_levels.size() != 0 ||
           reg_writes.size() != 0 || cfg_valid) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_calibration(input int ox, input int oy, input int oz, input int g);
    reg_write_t w;
    w.index = avma_pkg::RegOffsetX; w.data = ox[avma_pkg::CfgDataW-1:0];
    reg_writes.push_back(w);
    w.index = avma_pkg::RegOffsetY; w.data = oy[avma_pkg::CfgDataW-1:0];
    reg_writes.push_back(w);
    w.index = avma_pkg::RegOffsetZ; w.data = oz[avma_pkg::CfgDataW-1:0];
    reg_writes.push_back(w);
    w.index = avma_pkg::RegGravity; w.data = g[avma_pkg::CfgDataW-1:0];
    reg_writes.push_back(w);
    wait_drained();
  endtask

  task automatic push_sample(input int x, input int y, input int z);
    sample_t s;
    s.x = x[avma_pkg::AccelW-1:0];
    s.y = y[avma_pkg::AccelW-1:0];
    s.z = z[avma_pkg::AccelW-1:0];
    sample_backlog.push_back(s);
  endtask

  // Mostly a sensor at rest: small lateral axes, about one g on z, offsets cancelled
  task automatic push_random_sample();
    int corner [6];
    int kind;
    int jx;
    int jy;
    int jz;
    corner = '{-32768, -32767, -1, 0, 1, 32767};
    kind = $urandom_range(99);
    if (kind < 40) begin
      push_sample($urandom, $urandom, $urandom);
    end else if (kind < 90) begin
      jx = int'($urandom_range(0, 1600)) - 800 - int'(ofs_x);
      jy = int'($urandom_range(0, 1600)) - 800 - int'(ofs_y);
      jz = int'(grav) + int'($urandom_range(0, 3000)) - 1500;
      if ($urandom_range(1) == 1) jz = -jz;
      push_sample(jx, jy, jz - int'(ofs_z));
    end else begin
      push_sample(corner[$urandom_range(5)], corner[$urandom_range(5)],
                  corner[$urandom_range(5)]);
    end
  endtask

  initial begin
    int g;
    for (int i = 0; i < AvgWindow; i++) win_level[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset calibration; the first averages still see a partly empty window
    push_sample(0, 0, 0);
    push_sample(-240, 150, -1876);
    push_sample(-240, 150, -1876);
    push_sample(0, 0, 16384 - 1876);
    push_sample(32767, 32767, 32767);
    push_sample(-32768, -32768, -32768);
    push_sample(32767, -32768, 0);
    push_sample(1, -1, 1);
    push_sample(-240, 150, 14508);
    push_sample(-240, 150, -18260);
    push_sample(-240, 150, -1876);
    push_sample(-240, 150, -1876);
    wait_drained();

    // Most negative offsets and zero gravity: largest magnitude
    set_calibration(-4096, -4096, -4096, 0);
    push_sample(-32768, -32768, -32768);
    push_sample(0, 0, 0);
    push_sample(4096, 4096, 4096);
    push_sample(32767, -32768, 32767);
    push_sample(-32768, 32767, -32768);
    wait_drained();

    // Most positive offsets and full-scale gravity: most negative level
    set_calibration(4095, 4095, 4095, 32767);
    push_sample(32767, 32767, 32767);
    push_sample(-4095, -4095, -4095);
    push_sample(-4095, -4095, -4095);
    push_sample(-32768, -32768, -32768);
    push_sample(0, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct <= (ph < 2) ? 9 : (ph < 4) ? 63 : 0;
      recv_idle_pct <= (ph < 2) ? 63 : (ph < 4) ? 9 : 0;
      if (ph == 3) begin
        set_calibration(240, -150, 1876, 16384);
      end else begin
        g = ($urandom_range(3) == 0) ? int'($urandom_range(0, 32767))
                                     : 16384 + int'($urandom_range(0, 4000)) - 2000;
        set_calibration(int'($urandom_range(0, 8191)) - 4096,
                        int'($urandom_range(0, 8191)) - 4096,
                        int'($urandom_range(0, 8191)) - 4096, g);
      end
      if (ph == 0) begin
        // Hold the receiver off so the core backs up and stalls its input
        fork
          begin
            recv_hold <= 1'b1;
            repeat (400) @(posedge clk_i);
            recv_hold <= 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 285; n++) begin
        push_random_sample();
        // Pause the sender until the core has emptied
        if (ph == 2 && n == 140) wait_drained();
      end
      wait_drained();
    end

    if (errors == 0 && pending_levels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
